[rtl/cbpe_pkg.sv]
// ----------------------------------------------------------------------------
// cbpe_pkg
// Shared types and codes for the cursor barrier and portal engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cbpe_pkg;

  typedef enum logic [1:0] {
    ACT_MOVE   = 2'd0,
    ACT_WALL   = 2'd1,
    ACT_PORTAL = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_WALL   = 2'd1,
    EV_PORTAL = 2'd2,
    EV_RSVD   = 2'd3
  } event_t;

  localparam logic CFG_WALL_COUNT   = 1'b0;
  localparam logic CFG_PORTAL_COUNT = 1'b1;

  localparam logic [3:0] REL_B1 = 4'h1;
  localparam logic [3:0] REL_A1 = 4'h2;
  localparam logic [3:0] REL_A2 = 4'h4;
  localparam logic [3:0] REL_B2 = 4'h8;

  typedef struct packed {
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic               vert;
    logic        [14:0] len;
    logic        [15:0] ratio;
  } seg_t;

  // {after, before} of a point against a segment
  function automatic logic [1:0] side_of(input seg_t s, input logic vert,
                                         input logic signed [15:0] px,
                                         input logic signed [15:0] py);
    logic signed [16:0] c;
    logic signed [16:0] o;
    logic signed [16:0] e;
    logic signed [15:0] q;
    logic signed [15:0] qo;
    c  = vert ? 17'(py) : 17'(px);
    o  = vert ? 17'(s.oy) : 17'(s.ox);
    e  = o + $signed({2'b00, s.len});
    q  = vert ? px : py;
    qo = vert ? s.ox : s.oy;
    if (c >= o && c <= e) begin
      side_of = (q < qo) ? REL_B1[1:0] : REL_A1[1:0];
    end else begin
      side_of = 2'b00;
    end
  endfunction

endpackage

`default_nettype wire

[rtl/cursor_barrier_portal_engine_core.sv]
// ----------------------------------------------------------------------------
// cursor_barrier_portal_engine_core
// Pointer wall and portal engine over wall and portal table memories.
// Load requests write the tables when accepted. A move scans portals through
// PA, PB, PC and then walls through WA, WC per slot (registered memory reads);
// a portal hit runs one or two divider passes, a wall hit none or two.
// Reset clears control state, counts and the last position; table contents
// are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_barrier_portal_engine_core #(
  parameter int MAX_WALLS       = 16,
  parameter int MAX_PORTALS     = 16,
  parameter int RATIO_FRAC_BITS = 12
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         action,
  input  wire logic [3:0]         slot,
  input  wire logic               portal_end,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  input  wire logic               is_vertical,
  input  wire logic [14:0]        seg_length,
  input  wire logic [15:0]        scale_ratio,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              event_res,
  output logic signed [15:0]      new_x,
  output logic signed [15:0]      new_y,
  output logic [3:0]              hit_slot,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [4:0]         cfg_data
);

  localparam int WA = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int PA = (MAX_PORTALS > 1) ? $clog2(MAX_PORTALS) : 1;
  localparam int NW = 34 + RATIO_FRAC_BITS;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b00000000001,
    ST_PA   = 11'b00000000010,
    ST_PB   = 11'b00000000100,
    ST_PC   = 11'b00000001000,
    ST_D1   = 11'b00000010000,
    ST_D2   = 11'b00000100000,
    ST_WA   = 11'b00001000000,
    ST_WC   = 11'b00010000000,
    ST_WDX  = 11'b00100000000,
    ST_WDY  = 11'b01000000000,
    ST_DONE = 11'b10000000000
  } state_t;

  function automatic logic signed [15:0] sat16(input logic signed [NW-1:0] v);
    if (v > $signed(NW'(32767))) begin
      sat16 = 16'sh7fff;
    end else if (v < -$signed(NW'(32768))) begin
      sat16 = -16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  state_t state;

  logic [4:0] wall_count;
  logic [4:0] portal_count;
  logic signed [15:0] last_x;
  logic signed [15:0] last_y;

  cbpe_pkg::seg_t wmem [MAX_WALLS];
  cbpe_pkg::seg_t pmem [2*MAX_PORTALS];
  cbpe_pkg::seg_t w_rd;
  cbpe_pkg::seg_t p_rd;
  cbpe_pkg::seg_t seg_a;

  logic [WA-1:0] widx;
  logic [PA-1:0] pidx;
  logic          pend_sel;
  logic [8:0]    w_last;
  logic [8:0]    p_last;

  logic signed [15:0] mx;
  logic signed [15:0] my;

  logic signed [NW-1:0] div_num;
  logic        [15:0]   div_den;
  logic                 div_go;
  logic                 div_done;
  logic signed [NW-1:0] div_quo;

  logic signed [15:0] to_r;
  logic        [15:0] rto_r;
  logic               tvert;
  logic signed [15:0] across_r;
  logic signed [15:0] hy_r;

  logic [1:0]         ev_r;
  logic signed [15:0] rx;
  logic signed [15:0] ry;
  logic [3:0]         hs_r;

  logic accept;
  logic wr_wall;
  logic wr_portal;
  cbpe_pkg::seg_t in_seg;

  logic [3:0] pr;
  logic [3:0] cr;
  logic       first;
  logic       second;
  logic       pv;
  logic signed [15:0] p_c;
  logic signed [15:0] from_c;
  logic signed [15:0] to_c;
  logic [14:0]        lf_c;
  logic [14:0]        lto_c;
  logic [15:0]        rto_c;
  logic signed [16:0] odiff;
  logic signed [17:0] across_c;
  logic signed [16:0] pdiff;
  logic signed [32:0] prod_c;

  logic [1:0] wpr;
  logic [1:0] wcr;
  logic       whit;
  logic signed [15:0] hx_c;
  logic signed [15:0] hy_c;

  logic signed [33:0] v_c;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign wr_wall   = accept && (action == cbpe_pkg::ACT_WALL) &&
                     ({5'd0, slot} < 9'(MAX_WALLS));
  assign wr_portal = accept && (action == cbpe_pkg::ACT_PORTAL) &&
                     ({5'd0, slot} < 9'(MAX_PORTALS));
  assign in_seg    = '{ox: pos_x, oy: pos_y, vert: is_vertical,
                       len: seg_length, ratio: scale_ratio};

  assign w_last = ({4'd0, wall_count} >= 9'(MAX_WALLS)) ? 9'(MAX_WALLS - 1)
                                                        : 9'({4'd0, wall_count} - 9'd1);
  assign p_last = ({4'd0, portal_count} >= 9'(MAX_PORTALS)) ? 9'(MAX_PORTALS - 1)
                                                            : 9'({4'd0, portal_count} - 9'd1);

  always_ff @(posedge clk) begin
    if (wr_wall) begin
      wmem[WA'(slot)] <= in_seg;
    end
    w_rd <= wmem[widx];
  end

  always_ff @(posedge clk) begin
    if (wr_portal) begin
      pmem[{PA'(slot), portal_end}] <= in_seg;
    end
    p_rd <= pmem[{pidx, pend_sel}];
  end

  assign pend_sel = (state == ST_PA) ? 1'b0 : 1'b1;

  always_comb begin
    pv     = seg_a.vert;
    pr     = {cbpe_pkg::side_of(p_rd, pv, last_x, last_y),
              cbpe_pkg::side_of(seg_a, pv, last_x, last_y)};
    cr     = {cbpe_pkg::side_of(p_rd, pv, mx, my),
              cbpe_pkg::side_of(seg_a, pv, mx, my)};
    first  = |(pr & cbpe_pkg::REL_B1) && |(cr & cbpe_pkg::REL_A1);
    second = |(pr & cbpe_pkg::REL_B2) && |(cr & cbpe_pkg::REL_A2);
    p_c    = pv ? last_y : last_x;
    from_c = first ? (pv ? seg_a.oy : seg_a.ox) : (pv ? p_rd.oy : p_rd.ox);
    to_c   = first ? (pv ? p_rd.oy : p_rd.ox) : (pv ? seg_a.oy : seg_a.ox);
    lf_c   = first ? seg_a.len : p_rd.len;
    lto_c  = first ? p_rd.len : seg_a.len;
    rto_c  = first ? p_rd.ratio : seg_a.ratio;
    odiff  = pv ? (17'(p_rd.ox) - 17'(seg_a.ox)) : (17'(p_rd.oy) - 17'(seg_a.oy));
    across_c = first ? (18'(pv ? mx : my) + 18'(odiff))
                     : (18'(pv ? mx : my) - 18'(odiff));
    pdiff  = 17'(p_c) - 17'(from_c);
    prod_c = 33'(pdiff) * $signed({18'd0, lto_c});

    wpr    = cbpe_pkg::side_of(w_rd, w_rd.vert, last_x, last_y);
    wcr    = cbpe_pkg::side_of(w_rd, w_rd.vert, mx, my);
    whit   = (wpr[0] && wcr[1]) || (wpr[1] && wcr[0]);
    hx_c   = w_rd.vert ? last_x : mx;
    hy_c   = w_rd.vert ? my : last_y;

    v_c    = $signed(div_quo[33:0]) + 34'(to_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      wall_count   <= '0;
      portal_count <= '0;
      last_x       <= '0;
      last_y       <= '0;
      out_valid    <= 1'b0;
      div_go       <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == cbpe_pkg::CFG_WALL_COUNT) begin
          wall_count <= cfg_data;
        end else begin
          portal_count <= cfg_data;
        end
      end
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && action == cbpe_pkg::ACT_MOVE) begin
            mx   <= pos_x;
            my   <= pos_y;
            pidx <= '0;
            widx <= '0;
            ev_r <= cbpe_pkg::EV_NONE;
            rx   <= pos_x;
            ry   <= pos_y;
            hs_r <= '0;
            if (portal_count != 5'd0) begin
              state <= ST_PA;
            end else if (wall_count != 5'd0) begin
              state <= ST_WA;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_PA: begin
          state <= ST_PB;
        end
        ST_PB: begin
          seg_a <= p_rd;
          state <= ST_PC;
        end
        ST_PC: begin
          if (first || second) begin
            ev_r     <= cbpe_pkg::EV_PORTAL;
            hs_r     <= 4'(pidx);
            tvert    <= pv;
            across_r <= sat16(NW'(across_c));
            to_r     <= to_c;
            rto_r    <= rto_c;
            div_num  <= NW'(prod_c);
            div_den  <= {1'b0, (lf_c == 15'd0) ? 15'd1 : lf_c};
            div_go   <= 1'b1;
            state    <= ST_D1;
          end else if (9'(pidx) == p_last) begin
            state <= (wall_count != 5'd0) ? ST_WA : ST_DONE;
          end else begin
            pidx  <= pidx + 1'b1;
            state <= ST_PA;
          end
        end
        ST_D1: begin
          if (div_done) begin
            if (rto_r == 16'd0) begin
              rx    <= tvert ? across_r : sat16(NW'(v_c));
              ry    <= tvert ? sat16(NW'(v_c)) : across_r;
              state <= ST_DONE;
            end else begin
              div_num <= NW'(v_c) <<< RATIO_FRAC_BITS;
              div_den <= rto_r;
              div_go  <= 1'b1;
              state   <= ST_D2;
            end
          end
        end
        ST_D2: begin
          if (div_done) begin
            rx    <= tvert ? across_r : sat16(div_quo);
            ry    <= tvert ? sat16(div_quo) : across_r;
            state <= ST_DONE;
          end
        end
        ST_WA: begin
          state <= ST_WC;
        end
        ST_WC: begin
          if (whit) begin
            ev_r <= cbpe_pkg::EV_WALL;
            hs_r <= 4'(widx);
            if (w_rd.ratio == 16'd0) begin
              rx    <= hx_c;
              ry    <= hy_c;
              state <= ST_DONE;
            end else begin
              hy_r    <= hy_c;
              rto_r   <= w_rd.ratio;
              div_num <= NW'(hx_c) <<< RATIO_FRAC_BITS;
              div_den <= w_rd.ratio;
              div_go  <= 1'b1;
              state   <= ST_WDX;
            end
          end else if (9'(widx) == w_last) begin
            state <= ST_DONE;
          end else begin
            widx  <= widx + 1'b1;
            state <= ST_WA;
          end
        end
        ST_WDX: begin
          if (div_done) begin
            rx      <= sat16(div_quo);
            div_num <= NW'(hy_r) <<< RATIO_FRAC_BITS;
            div_den <= rto_r;
            div_go  <= 1'b1;
            state   <= ST_WDY;
          end
        end
        ST_WDY: begin
          if (div_done) begin
            ry    <= sat16(div_quo);
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            last_x    <= rx;
            last_y    <= ry;
            event_res <= ev_r;
            new_x     <= rx;
            new_y     <= ry;
            hit_slot  <= hs_r;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  cbpe_div #(
    .NW (NW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_D1 || state == ST_D2 || state == ST_WDX ||
                  state == ST_WDY))
    else $error("divider finished outside a divide step");

  a_move_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && action == cbpe_pkg::ACT_MOVE) |=> (state != ST_IDLE))
    else $error("move request did not start a scan");

  a_no_hit_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == cbpe_pkg::EV_NONE) |-> (hit_slot == 4'd0))
    else $error("slot reported without a hit");

endmodule

`default_nettype wire

[rtl/cbpe_div.sv]
// ----------------------------------------------------------------------------
// cbpe_div
// Signed by unsigned restoring divider, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module cbpe_div #(
  parameter int NW = 46
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 go,
  input  wire logic signed [NW-1:0] num,
  input  wire logic        [15:0]   den,
  output logic                      done,
  output logic signed [NW-1:0]      quo
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] mag;
  logic [15:0]   rem;
  logic          neg;
  logic [16:0]   rem_sh;
  logic          qbit;
  logic [15:0]   rem_next;

  always_comb begin
    rem_sh   = {rem, mag[NW-1]};
    qbit     = (rem_sh >= {1'b0, den});
    rem_next = qbit ? 16'(rem_sh - {1'b0, den}) : rem_sh[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= num[NW-1];
        mag  <= num[NW-1] ? NW'(-num) : NW'(num);
        rem  <= '0;
      end else if (busy) begin
        rem <= rem_next;
        mag <= {mag[NW-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? $signed(-mag) : $signed(mag);

endmodule

`default_nettype wire
